### sv/pcan_pkg.sv
// Shared types and constants for the path canonicalizer.
package pcan_pkg;
  localparam int PATH_LEN_DEF  = 64;
  localparam int TOKEN_LEN_DEF = 15;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BCOPY, S_BCOPY_W, S_TCHK, S_APP_SL, S_APP_TOK,
    S_POP, S_POP_W, S_EMIT, S_EMIT_W
  } bstate_t;
endpackage

### sv/pcan_if.sv
// Valid/ready stream interfaces for input items and result items.
interface pcan_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] ch;
  modport source (output valid, action, ch, input ready);
  modport sink (input valid, action, ch, output ready);
endinterface

interface pcan_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] path_char;
  logic       last;
  modport source (output valid, status, path_char, last, input ready);
  modport sink (input valid, status, path_char, last, output ready);
endinterface

### sv/path_canonicalizer_top.sv
// Top level of the path canonicalizer.
// Items are taken into a four-entry queue, one per cycle while it has room; the back end
// processes them one at a time. A plain character is appended to the token. A closing slash
// or NUL checks each token character, then writes the separator where needed and the token
// characters into the work store. A ".." scans back over the work store one character at a
// time, and starting from the base first copies the base into the work store character by
// character. The final NUL passes through a setup state, then streams the path at one result
// per cycle when out_ready stays high.
module path_canonicalizer_top #(
  parameter int PATH_LEN  = pcan_pkg::PATH_LEN_DEF,
  parameter int TOKEN_LEN = pcan_pkg::TOKEN_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_path_char,
  output logic       out_last
);
  import pcan_pkg::*;
  pcan_in_if  in_ch_if ();
  pcan_out_if out_ch_if ();
  logic  q_full, q_push, q_pop, q_empty;
  item_t q_wdata, q_rdata;

  assign in_ch_if.valid = in_valid;
  assign in_ch_if.action = in_action;
  assign in_ch_if.ch = in_ch;
  assign in_ready = in_ch_if.ready;
  assign out_valid = out_ch_if.valid;
  assign out_ch_if.ready = out_ready;
  assign out_status = out_ch_if.status;
  assign out_path_char = out_ch_if.path_char;
  assign out_last = out_ch_if.last;

  pcan_front u_front (.clk, .rst_n, .in_ch(in_ch_if.sink), .q_full, .q_push, .q_wdata);
  pcan_queue u_queue (.clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty));
  pcan_back #(.PATH_LEN(PATH_LEN), .TOKEN_LEN(TOKEN_LEN)) u_back (
    .clk, .rst_n, .q_empty, .q_rdata, .q_pop, .out_ch(out_ch_if.source));
endmodule

### sv/pcan_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/pcan_queue.sv
// Short item queue between the front and back ends.
module pcan_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcan_pkg::item_t     wdata,
  output logic                full,
  input  logic                pop,
  output pcan_pkg::item_t     rdata,
  output logic                empty
);
  import pcan_pkg::*;
  item_t      q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rdata = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end
`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue count out of range");
`endif
endmodule

### sv/pcan_front.sv
// Front end: accepts input transfers and feeds the item queue.
module pcan_front (
  input  logic            clk,
  input  logic            rst_n,
  pcan_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output pcan_pkg::item_t q_wdata
);
  import pcan_pkg::*;
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;
  assign q_wdata = '{action: in_ch.action, ch: in_ch.ch};
`ifndef ASSERT_OFF
  a_push_hs: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_ch.valid && in_ch.ready))
    else $error("push without transfer");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
    else $error("push while full");
  a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_full)
    else $error("ready mismatch");
`endif
endmodule

### sv/pcan_back.sv
// Back end: builds the canonical path and streams results.
module pcan_back #(
  parameter int PATH_LEN  = pcan_pkg::PATH_LEN_DEF,
  parameter int TOKEN_LEN = pcan_pkg::TOKEN_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  pcan_pkg::item_t q_rdata,
  output logic            q_pop,
  pcan_out_if.source      out_ch
);
  import pcan_pkg::*;
  localparam int AW = $clog2(PATH_LEN);
  localparam int LW = AW + 1;
  localparam int TW = $clog2(TOKEN_LEN + 1);
  localparam int TAW = $clog2(TOKEN_LEN);

  bstate_t st_r, st_nxt;
  logic [LW-1:0] blen_r, blen_nxt, wlen_r, wlen_nxt, idx_r, idx_nxt;
  logic [TW-1:0] tlen_r, tlen_nxt, tidx_r, tidx_nxt;
  logic [1:0] phase_r, phase_nxt, err_r, err_nxt;
  logic bopen_r, bopen_nxt, bad_r, bad_nxt, fin_r, fin_nxt;
  logic [7:0] t1_r, t1_nxt;
  logic [7:0] tok_r [TOKEN_LEN];
  logic tok_we;
  logic [7:0] tok_wd;

  // token length saved across close (tlen_r is cleared at close)
  logic [TW-1:0] tlen_r_sv, tsv_nxt;

  logic          b_we, w_we;
  logic [AW-1:0] b_wa, b_ra, w_wa, w_ra;
  logic [7:0]    b_wd, b_rd, w_wd, w_rd;

  logic       ov_r, ov_nxt;
  logic [1:0] os_r, os_nxt;
  logic [7:0] oc_r, oc_nxt;
  logic       ol_r, ol_nxt;

  pcan_ram #(.WIDTH(8), .DEPTH(PATH_LEN)) u_base (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  pcan_ram #(.WIDTH(8), .DEPTH(PATH_LEN)) u_work (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));

  assign out_ch.valid = ov_r;
  assign out_ch.status = os_r;
  assign out_ch.path_char = oc_r;
  assign out_ch.last = ol_r;
  wire out_free = !ov_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (tok_we) tok_r[tlen_r[TAW-1:0]] <= tok_wd;
    os_r <= os_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt;
    t1_r <= t1_nxt; idx_r <= idx_nxt; tidx_r <= tidx_nxt;
    bad_r <= bad_nxt; fin_r <= fin_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; blen_r <= LW'(1); wlen_r <= '0; tlen_r <= '0;
      phase_r <= 2'd0; err_r <= ST_OK; bopen_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; blen_r <= blen_nxt; wlen_r <= wlen_nxt; tlen_r <= tlen_nxt;
      phase_r <= phase_nxt; err_r <= err_nxt; bopen_r <= bopen_nxt; ov_r <= ov_nxt;
    end
  end

  // base entry 0 holds '/' implicitly whenever the base was reset to root
  logic broot_r, broot_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) broot_r <= 1'b1;
    else broot_r <= broot_nxt;
  end

  always_comb begin
    logic [7:0] c;
    logic [7:0] tc;
    c = q_rdata.ch;
    st_nxt = st_r; blen_nxt = blen_r; wlen_nxt = wlen_r; tlen_nxt = tlen_r;
    phase_nxt = phase_r; err_nxt = err_r; bopen_nxt = bopen_r; broot_nxt = broot_r;
    idx_nxt = idx_r; tidx_nxt = tidx_r; t1_nxt = t1_r;
    bad_nxt = bad_r; fin_nxt = fin_r;
    ov_nxt = ov_r && !out_ch.ready; os_nxt = os_r; oc_nxt = oc_r; ol_nxt = ol_r;
    q_pop = 1'b0; tok_we = 1'b0; tok_wd = c;
    b_we = 1'b0; b_wa = '0; b_wd = c; b_ra = idx_r[AW-1:0];
    w_we = 1'b0; w_wa = '0; w_wd = c; w_ra = idx_r[AW-1:0];
    tc = tok_r[tidx_r[TAW-1:0]];
    case (st_r)
      S_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        if (!q_rdata.action) begin
          if (c == CH_NUL) begin
            if (!bopen_r || blen_r == '0) begin blen_nxt = LW'(1); broot_nxt = 1'b1; end
            bopen_nxt = 1'b0;
          end else begin
            if (!bopen_r) begin
              bopen_nxt = 1'b1; broot_nxt = 1'b0;
              b_we = 1'b1; b_wa = '0; blen_nxt = LW'(1);
            end else if (blen_r < LW'(PATH_LEN - 1)) begin
              b_we = 1'b1; b_wa = blen_r[AW-1:0]; blen_nxt = blen_r + LW'(1);
            end
          end
        end else if (phase_r[1]) begin
          if (c == CH_NUL) begin fin_nxt = 1'b1; st_nxt = S_EMIT; end
        end else if (phase_r == 2'd0) begin
          if (c == CH_SPACE) begin
          end else if (c == CH_SLASH) begin
            phase_nxt = 2'd1; tlen_nxt = '0;
            w_we = 1'b1; w_wa = '0; w_wd = CH_SLASH; wlen_nxt = LW'(1);
          end else begin
            phase_nxt = 2'd1; tlen_nxt = '0;
            // copy base, then reprocess this char
            if (c == CH_NUL) fin_nxt = 1'b1; else fin_nxt = 1'b0;
            t1_nxt = c; idx_nxt = '0; st_nxt = S_BCOPY;
          end
        end else begin
          if (c == CH_SLASH || c == CH_NUL) begin
            fin_nxt = (c == CH_NUL);
            tidx_nxt = '0; bad_nxt = 1'b0; st_nxt = S_TCHK;
          end else if (tlen_r >= TW'(TOKEN_LEN)) begin
            phase_nxt = 2'd2; err_nxt = ST_INVALID;
          end else begin
            tok_we = 1'b1; tlen_nxt = tlen_r + TW'(1);
          end
        end
      end
      S_BCOPY: begin
        if (idx_r == blen_r) begin
          wlen_nxt = blen_r;
          if (fin_r) st_nxt = S_EMIT;
          else if (t1_r == CH_SLASH) begin tidx_nxt = '0; bad_nxt = 1'b0; st_nxt = S_TCHK; end
          else begin
            tok_we = 1'b1; tok_wd = t1_r; tlen_nxt = TW'(1); st_nxt = S_IDLE;
          end
        end else st_nxt = S_BCOPY_W;
      end
      S_BCOPY_W: begin
        w_we = 1'b1; w_wa = idx_r[AW-1:0];
        w_wd = (idx_r == '0 && broot_r) ? CH_SLASH : b_rd;
        idx_nxt = idx_r + LW'(1); st_nxt = S_BCOPY;
      end
      S_TCHK: begin
        if (tlen_r == '0 || (tlen_r == TW'(1) && tok_r[0] == CH_DOT)) begin
          tlen_nxt = '0; st_nxt = fin_r ? S_EMIT : S_IDLE;
        end else if (tlen_r == TW'(2) && tok_r[0] == CH_DOT && tok_r[1] == CH_DOT) begin
          tlen_nxt = '0;
          if (wlen_r <= LW'(1)) begin
            w_we = 1'b1; w_wd = CH_SLASH; wlen_nxt = LW'(1);
            st_nxt = fin_r ? S_EMIT : S_IDLE;
          end else begin
            idx_nxt = wlen_r - LW'(1); st_nxt = S_POP;
          end
        end else if (tidx_r != tlen_r) begin
          if (tc == CH_SLASH || tc == CH_SPACE || tc == CH_TAB) bad_nxt = 1'b1;
          tidx_nxt = tidx_r + TW'(1);
        end else begin
          tlen_nxt = '0;
          if (bad_r) begin
            phase_nxt = 2'd2; err_nxt = ST_INVALID; st_nxt = fin_r ? S_EMIT : S_IDLE;
          end else begin
            idx_nxt = '0; st_nxt = S_APP_SL; w_ra = '0;
          end
        end
      end
      S_APP_SL: begin
        // w_rd holds entry 0; root path has length 1 and '/'
        if (wlen_r == LW'(1) && w_rd == CH_SLASH) begin
          if ((LW+1)'(1) + (LW+1)'(tlen_r_sv) >= (LW+1)'(PATH_LEN)) begin
            phase_nxt = 2'd2; err_nxt = ST_TOO_LONG; st_nxt = fin_r ? S_EMIT : S_IDLE;
          end else begin
            tidx_nxt = '0; st_nxt = S_APP_TOK;
          end
        end else if ((LW+1)'(wlen_r) + (LW+1)'(1) + (LW+1)'(tlen_r_sv)
                     >= (LW+1)'(PATH_LEN)) begin
          phase_nxt = 2'd2; err_nxt = ST_TOO_LONG; st_nxt = fin_r ? S_EMIT : S_IDLE;
        end else begin
          w_we = 1'b1; w_wa = wlen_r[AW-1:0]; w_wd = CH_SLASH;
          wlen_nxt = wlen_r + LW'(1); tidx_nxt = '0; st_nxt = S_APP_TOK;
        end
      end
      S_APP_TOK: begin
        if (tidx_r == tlen_r_sv) st_nxt = fin_r ? S_EMIT : S_IDLE;
        else begin
          w_we = 1'b1; w_wa = wlen_r[AW-1:0]; w_wd = tc;
          wlen_nxt = wlen_r + LW'(1); tidx_nxt = tidx_r + TW'(1);
        end
      end
      S_POP: st_nxt = S_POP_W;
      S_POP_W: begin
        if (idx_r == '0) begin
          w_we = 1'b1; w_wd = CH_SLASH; wlen_nxt = LW'(1);
          st_nxt = fin_r ? S_EMIT : S_IDLE;
        end else if (w_rd == CH_SLASH) begin
          wlen_nxt = idx_r; st_nxt = fin_r ? S_EMIT : S_IDLE;
        end else begin
          idx_nxt = idx_r - LW'(1); st_nxt = S_POP;
        end
      end
      S_EMIT: begin
        idx_nxt = '0; w_ra = '0;
        if (phase_r[1]) begin
          if (out_free) begin
            ov_nxt = 1'b1; os_nxt = err_r; oc_nxt = CH_NUL; ol_nxt = 1'b1;
            phase_nxt = 2'd0; err_nxt = ST_OK; tlen_nxt = '0; wlen_nxt = '0;
            st_nxt = S_IDLE;
          end
        end else begin
          if (wlen_r == '0) begin
            w_we = 1'b1; w_wd = CH_SLASH; wlen_nxt = LW'(1);
          end
          st_nxt = S_EMIT_W;
        end
      end
      S_EMIT_W: if (out_free) begin
        ov_nxt = 1'b1; os_nxt = ST_OK; oc_nxt = w_rd;
        ol_nxt = (idx_r + LW'(1) == wlen_r);
        if (idx_r + LW'(1) == wlen_r) begin
          phase_nxt = 2'd0; err_nxt = ST_OK; tlen_nxt = '0; wlen_nxt = '0;
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + LW'(1); w_ra = idx_r[AW-1:0] + AW'(1); st_nxt = S_EMIT_W;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign tsv_nxt = (st_r == S_TCHK) ? tlen_r : tlen_r_sv;
  always_ff @(posedge clk) tlen_r_sv <= tsv_nxt;

`ifndef ASSERT_OFF
  a_wlen_bound: assert property (@(posedge clk) disable iff (!rst_n) wlen_r < LW'(PATH_LEN))
    else $error("work length overflow");
  a_blen_bound: assert property (@(posedge clk) disable iff (!rst_n) blen_r < LW'(PATH_LEN))
    else $error("base length overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> st_r == S_IDLE)
    else $error("pop outside idle");
  a_tok_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= TW'(TOKEN_LEN))
    else $error("token length overflow");
`endif
endmodule

### bench/tb_path_canonicalizer_top.sv
// Self-checking testbench for path_canonicalizer_top: directed and random paths.
module tb_path_canonicalizer_top;
  import pcan_pkg::*;

  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] path_char;
    logic       last;
  } path_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pcan_in_if  in_ch();
  pcan_out_if out_ch();

  path_canonicalizer_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_action     (in_ch.action),
    .in_ch         (in_ch.ch),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_path_char (out_ch.path_char),
    .out_last      (out_ch.last)
  );

  always #2 clk = ~clk;

  // expected path results, oldest first
  path_res_t exp_path_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int paths_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int cycles = 0;

  // canonicalizer shadow state
  logic [7:0] base_mem [PATH_LEN_DEF];
  logic [7:0] work_mem [PATH_LEN_DEF];
  logic [7:0] tok_mem  [TOKEN_LEN_DEF];
  int         base_len = 1;
  int         work_len = 0;
  int         tok_len = 0;
  logic [1:0] arg_phase = 2'd0;
  logic [1:0] pend_err = ST_OK;
  bit         loading = 1'b0;

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_TOKENS = 2'd1;
  localparam logic [1:0] PH_ERROR = 2'd2;

  function automatic void set_root();
    work_mem[0] = CH_SLASH;
    work_len = 1;
  endfunction

  function automatic void pop_dir();
    int i;
    if (work_len <= 1) begin
      set_root();
      return;
    end
    i = work_len - 1;
    while (i > 0 && work_mem[i] != CH_SLASH) i--;
    if (i == 0) set_root();
    else work_len = i;
  endfunction

  function automatic logic [1:0] close_tok();
    int n;
    int at;
    n = tok_len;
    tok_len = 0;
    if (n == 0) return ST_OK;
    if (n == 1 && tok_mem[0] == CH_DOT) return ST_OK;
    if (n == 2 && tok_mem[0] == CH_DOT && tok_mem[1] == CH_DOT) begin
      pop_dir();
      return ST_OK;
    end
    for (int k = 0; k < n; k++)
      if (tok_mem[k] == CH_SLASH || tok_mem[k] == CH_SPACE || tok_mem[k] == CH_TAB)
        return ST_INVALID;
    if (work_len == 1 && work_mem[0] == CH_SLASH) begin
      if (1 + n >= PATH_LEN_DEF) return ST_TOO_LONG;
      at = 1;
    end else begin
      if (work_len + 1 + n >= PATH_LEN_DEF) return ST_TOO_LONG;
      work_mem[work_len] = CH_SLASH;
      at = work_len + 1;
    end
    for (int k = 0; k < n; k++) work_mem[at + k] = tok_mem[k];
    work_len = at + n;
    return ST_OK;
  endfunction

  function automatic void copy_base();
    for (int k = 0; k < base_len; k++) work_mem[k] = base_mem[k];
    work_len = base_len;
  endfunction

  function automatic void emit_path();
    path_res_t r;
    if (arg_phase >= PH_ERROR) begin
      r.status = pend_err;
      r.path_char = CH_NUL;
      r.last = 1'b1;
      exp_path_q.push_back(r);
    end else begin
      if (work_len == 0) set_root();
      for (int k = 0; k < work_len; k++) begin
        r.status = ST_OK;
        r.path_char = work_mem[k];
        r.last = (k + 1 == work_len);
        exp_path_q.push_back(r);
      end
    end
    arg_phase = PH_LEAD;
    pend_err = ST_OK;
    tok_len = 0;
    work_len = 0;
  endfunction

  function automatic void predict_path(logic action, logic [7:0] c);
    logic [1:0] rc;
    if (!action) begin
      if (c == CH_NUL) begin
        if (!loading) base_len = 0;
        if (base_len == 0) begin
          base_mem[0] = CH_SLASH;
          base_len = 1;
        end
        loading = 1'b0;
      end else begin
        if (!loading) begin
          base_len = 0;
          loading = 1'b1;
        end
        if (base_len < PATH_LEN_DEF - 1) begin
          base_mem[base_len] = c;
          base_len++;
        end
      end
      return;
    end
    if (arg_phase >= PH_ERROR) begin
      if (c == CH_NUL) emit_path();
      return;
    end
    if (arg_phase == PH_LEAD) begin
      if (c == CH_SPACE) return;
      if (c == CH_NUL) begin
        copy_base();
        arg_phase = PH_TOKENS;
        emit_path();
        return;
      end
      arg_phase = PH_TOKENS;
      tok_len = 0;
      if (c == CH_SLASH) begin
        set_root();
        return;
      end
      copy_base();
    end
    if (c == CH_SLASH || c == CH_NUL) begin
      rc = close_tok();
      if (rc != ST_OK) begin
        arg_phase = PH_ERROR;
        pend_err = rc;
      end
      if (c == CH_NUL) emit_path();
      return;
    end
    if (tok_len >= TOKEN_LEN_DEF) begin
      arg_phase = PH_ERROR;
      pend_err = ST_INVALID;
      return;
    end
    tok_mem[tok_len] = c;
    tok_len++;
  endfunction

  task automatic send_item(logic action, logic [7:0] c);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      while ($urandom_range(99) < send_idle) @(posedge clk);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= action;
    in_ch.ch <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_path(action, c);
    items_sent++;
  endtask

  task automatic send_str(logic action, string s);
    for (int i = 0; i < s.len(); i++) send_item(action, s[i]);
    send_item(action, CH_NUL);
  endtask

  // result checker and receiver pacing
  always @(posedge clk) begin
    path_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (exp_path_q.size() == 0) begin
        $error("unexpected result: status %0d path_char %h last %0d",
               out_ch.status, out_ch.path_char, out_ch.last);
        errors++;
      end else begin
        e = exp_path_q.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.path_char !== e.path_char) begin
          $error("path_char: expected %h, got %h", e.path_char, out_ch.path_char);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_ch.last);
          errors++;
        end
        if (e.last) paths_seen++;
      end
    end
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", exp_path_q.size());
      $display("FAIL path_canonicalizer_top");
      $finish;
    end
  end

  task automatic test_basic_paths();
    send_str(1'b1, "");
    send_str(1'b1, "   ");
    send_str(1'b1, "/");
    send_str(1'b1, "  /a/b/../c/./d//e/");
    send_str(1'b1, "/..");
    send_str(1'b1, "..");
    send_str(1'b1, "/abcdefghijklmno");
    send_str(1'b1, "/abcdefghijklmnop/x");
    send_str(1'b1, "/a b");
    send_str(1'b1, "/a\tb/c");
    send_str(1'b1, "/ ./. /..");
  endtask

  task automatic test_directory_loads();
    send_str(1'b0, "/usr/local");
    send_str(1'b1, "bin/../lib");
    send_str(1'b1, "");
    send_str(1'b0, "");
    send_str(1'b1, "x");
    send_str(1'b0, "abc");
    send_str(1'b1, "..");
    send_str(1'b0, "/aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
    send_str(1'b1, "");
    send_str(1'b1, "q");
    send_str(1'b0, "/");
    send_item(1'b1, "k");
    send_str(1'b0, "/mid");
    send_str(1'b1, "/j");
    send_str(1'b1, "/aaaaaaaaaaaaaaa/bbbbbbbbbbbbbbb/ccccccccccccccc/ddddddddddddddd");
    send_item(1'b1, CH_SLASH);
    send_item(1'b1, 8'hff);
    send_item(1'b1, 8'h80);
    send_item(1'b1, 8'h7f);
    send_item(1'b1, CH_NUL);
  endtask

  task automatic send_random_path();
    int kind;
    int n;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = (kind < 2) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(1, 255)));
      send_item(1'b0, CH_NUL);
      return;
    end
    if (kind < 20) begin
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) send_item(1'b1, 8'($urandom_range(0, 255)) | 8'h01);
      send_item(1'b1, CH_NUL);
      return;
    end
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_item(1'b1, CH_SPACE);
    if ($urandom_range(1)) send_item(1'b1, CH_SLASH);
    n = $urandom_range(0, 5);
    for (int t = 0; t < n; t++) begin
      kind = $urandom_range(99);
      if (kind < 15) send_item(1'b1, CH_DOT);
      else if (kind < 35) begin
        send_item(1'b1, CH_DOT);
        send_item(1'b1, CH_DOT);
      end else begin
        int len;
        len = (kind < 40) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          kind = $urandom_range(99);
          if (kind < 3) c = CH_SPACE;
          else if (kind < 5) c = CH_TAB;
          else if (kind < 10) c = 8'($urandom_range(1, 255));
          else c = 8'($urandom_range(8'h61, 8'h7a));
          if (c == CH_SLASH) c = 8'h5f;
          send_item(1'b1, c);
        end
      end
      if (t + 1 < n || $urandom_range(3) == 0) send_item(1'b1, CH_SLASH);
    end
    send_item(1'b1, CH_NUL);
  endtask

  task automatic test_random_paths(int n_items, int s_idle, int r_idle, int hold);
    int stop_at;
    send_idle = s_idle;
    recv_idle = r_idle;
    hold_cycles = hold;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_path();
  endtask

  initial begin
    int wait_cnt;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.ch = CH_NUL;
    out_ch.ready = 1'b0;
    base_mem[0] = CH_SLASH;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    recv_idle = 10;
    test_basic_paths();
    test_directory_loads();
    test_random_paths(60, 26, 78, 0);
    test_random_paths(60, 78, 26, 0);
    test_random_paths(60, 0, 0, 400);
    in_ch.valid <= 1'b0;
    wait_cnt = 0;
    while (exp_path_q.size() > 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    $display("sent %0d items, checked %0d results over %0d paths",
             items_sent, results_seen, paths_seen);
    $display("covered loads, relative and absolute paths, dot tokens, errors, stalls");
    if (errors == 0 && exp_path_q.size() == 0) begin
      $display("PASS path_canonicalizer_top");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, exp_path_q.size());
      $display("FAIL path_canonicalizer_top");
    end
    $finish;
  end
endmodule

### files.f
sv/pcan_pkg.sv
sv/pcan_if.sv
sv/pcan_ram.sv
sv/pcan_queue.sv
sv/pcan_front.sv
sv/pcan_back.sv
sv/path_canonicalizer_top.sv
bench/tb_path_canonicalizer_top.sv
